@@ hdl/lms_pkg.sv @@
// Shared types and constants for the list merge sorter.
// No dependencies; compiled first.
`default_nettype none

package lms_pkg;

   // Width of one list element
   localparam int DATA_W = 32;

   // Controller phases: collect the list, merge passes, stream out
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_MERGE,
      ST_OUT
   } lms_state_type;

endpackage : lms_pkg

`default_nettype wire

@@ hdl/lms_if.sv @@
// Valid/ready channel interfaces for the list merge sorter.
// Depends on lms_pkg for the element width.
`default_nettype none

// Input channel: one list element per beat
interface lms_req_if import lms_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] value;
   logic                     last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface : lms_req_if

// Result channel: one sorted element per beat
interface lms_rsp_if import lms_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sorted_value;
   logic                     end_of_list;
   logic                     overflow;

   modport source (output valid, output sorted_value, output end_of_list,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_value, input end_of_list,
                   input overflow, output ready);
endinterface : lms_rsp_if

`default_nettype wire

@@ hdl/lms_ram.sv @@
// Synchronous RAM, one write port and two registered read ports.
// A read of the entry written in the same cycle returns the new data.
`default_nettype none

module lms_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 32
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [DATA_W-1:0] rd_data_a,
   output logic      [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [2**ADDR_W];

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read ports with write-through forwarding
   always_ff @(posedge clock) begin
      rd_data_a <= (we && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
      rd_data_b <= (we && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
   end

endmodule : lms_ram

`default_nettype wire

@@ hdl/list_merge_sorter.sv @@
// List merge sorter: collects a list, sorts it by bottom-up merge passes
// between two RAMs, and streams the sorted list out.
// Depends on lms_pkg, lms_if (channel interfaces) and lms_ram.
//
// Usage:
//   req channel: one signed 32-bit value per beat; last marks the final value.
//     Up to MAX_ITEMS values are kept; later ones are dropped and the list is
//     flagged as overflowed. req.ready is high only while collecting.
//   rsp channel: the kept values in ascending order, one per beat, equal
//     values in arrival order; end_of_list on the final beat, overflow on
//     every beat of a list that lost values.
//   Timing for a list of n kept values: the values are loaded as offered,
//     then ceil(log2 n) merge passes run (one element per cycle per pass,
//     set by the single write port of the target RAM), then one result per
//     cycle while the receiver takes them. The first result is valid the
//     cycle after the last merge pass ends.
//   Stall: a result holds on the port until taken; no input is accepted
//     until the final result of the list has been taken.
//   Reset (synchronous): returns to collecting with an empty list and the
//     overflow flag clear. RAM contents are not cleared.
`default_nettype none

module list_merge_sorter import lms_pkg::*; #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lms_req_if.sink    req,
   lms_rsp_if.source  rsp
);

   localparam int ADDR_W = $clog2(MAX_ITEMS);
   localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
   localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ITEMS);

   // Control and position registers
   lms_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] mid_ff, mid_in;
   logic [CNT_W-1:0] hi_ff, hi_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             ovf_ff, ovf_in;
   logic             src_ff, src_in;

   // RAM ports
   logic              a_we, b_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [CNT_W-1:0]  rd_pos_i, rd_pos_j;
   logic [DATA_W-1:0] a_rd_i, a_rd_j, b_rd_i, b_rd_j;

   // Merge datapath
   logic signed [DATA_W-1:0] head_i, head_j, pick;
   logic             req_take, store_ok, sort_short, take_i;
   logic             blk_done, pass_done, sort_end, rsp_take, rsp_final;
   logic [CNT_W-1:0] n_start;
   logic [CNT_W:0]   w_dbl;

   // Next block bounds
   logic [CNT_W-1:0] blk_lo, n_sel, blk_mid, blk_hi;
   logic [CNT_W:0]   blk_w;
   logic [CNT_W+1:0] sum_mid, sum_hi, n_wide;

   // Two RAMs; passes ping-pong between them, src_ff selects the source
   lms_ram #(.ADDR_W(ADDR_W), .DATA_W(DATA_W)) u_ram_a (
      .clock     (clock),
      .we        (a_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_pos_i[ADDR_W-1:0]),
      .rd_addr_b (rd_pos_j[ADDR_W-1:0]),
      .rd_data_a (a_rd_i),
      .rd_data_b (a_rd_j)
   );

   lms_ram #(.ADDR_W(ADDR_W), .DATA_W(DATA_W)) u_ram_b (
      .clock     (clock),
      .we        (b_we),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_pos_i[ADDR_W-1:0]),
      .rd_addr_b (rd_pos_j[ADDR_W-1:0]),
      .rd_data_a (b_rd_i),
      .rd_data_b (b_rd_j)
   );

   // Status terms
   always_comb begin
      req_take   = req.valid && req.ready;
      rsp_take   = rsp.valid && rsp.ready;
      store_ok   = count_ff < CAP;
      n_start    = count_ff + CNT_W'(store_ok);
      sort_short = n_start <= CNT_W'(1);
      head_i     = src_ff ? b_rd_i : a_rd_i;
      head_j     = src_ff ? b_rd_j : a_rd_j;
      // stable merge: left run wins ties
      take_i     = (i_ff < mid_ff) && (!(j_ff < hi_ff) || (head_i <= head_j));
      pick       = take_i ? head_i : head_j;
      blk_done   = (k_ff + CNT_W'(1)) == hi_ff;
      pass_done  = hi_ff == n_ff;
      w_dbl      = {width_ff, 1'b0};
      sort_end   = w_dbl >= {1'b0, n_ff};
      rsp_final  = k_ff == (n_ff - CNT_W'(1));
   end

   // Base and run width of the block that starts next
   always_comb begin
      if (state_ff == ST_LOAD) begin
         blk_lo = '0;
         blk_w  = (CNT_W+1)'(1);
         n_sel  = n_start;
      end else if (pass_done) begin
         blk_lo = '0;
         blk_w  = w_dbl;
         n_sel  = n_ff;
      end else begin
         blk_lo = hi_ff;
         blk_w  = {1'b0, width_ff};
         n_sel  = n_ff;
      end
   end

   // Clip block bounds to the list length
   assign sum_mid = {2'b00, blk_lo} + {1'b0, blk_w};
   assign sum_hi  = {2'b00, blk_lo} + {blk_w, 1'b0};
   assign n_wide  = {2'b00, n_sel};
   assign blk_mid = (sum_mid > n_wide) ? n_sel : sum_mid[CNT_W-1:0];
   assign blk_hi  = (sum_hi > n_wide) ? n_sel : sum_hi[CNT_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take && req.last) begin
               state_in = sort_short ? ST_OUT : ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (blk_done && pass_done && sort_end) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_take && rsp_final) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Datapath and RAM control
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      n_in     = n_ff;
      width_in = width_ff;
      mid_in   = mid_ff;
      hi_in    = hi_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      src_in   = src_ff;
      a_we     = 1'b0;
      b_we     = 1'b0;
      wr_addr  = k_ff[ADDR_W-1:0];
      wr_data  = pick;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               // append while room remains, else drop and flag
               if (store_ok) begin
                  a_we     = 1'b1;
                  wr_addr  = count_ff[ADDR_W-1:0];
                  wr_data  = req.value;
                  count_in = n_start;
               end else begin
                  ovf_in = 1'b1;
               end
               // first pass: runs of one, source is RAM A
               if (req.last) begin
                  n_in     = n_start;
                  width_in = CNT_W'(1);
                  mid_in   = blk_mid;
                  hi_in    = blk_hi;
                  i_in     = '0;
                  j_in     = blk_mid;
                  k_in     = '0;
                  src_in   = 1'b0;
               end
            end
         end
         ST_MERGE: begin
            a_we = src_ff;
            b_we = !src_ff;
            if (!blk_done) begin
               i_in = i_ff + CNT_W'(take_i);
               j_in = j_ff + CNT_W'(!take_i);
               k_in = k_ff + CNT_W'(1);
            end else if (!pass_done) begin
               // next block of the same pass
               i_in   = hi_ff;
               j_in   = blk_mid;
               mid_in = blk_mid;
               hi_in  = blk_hi;
               k_in   = k_ff + CNT_W'(1);
            end else begin
               // pass done: swap RAM roles, double the run width
               src_in = !src_ff;
               i_in   = '0;
               k_in   = '0;
               if (!sort_end) begin
                  width_in = w_dbl[CNT_W-1:0];
                  mid_in   = blk_mid;
                  hi_in    = blk_hi;
                  j_in     = blk_mid;
               end
            end
         end
         ST_OUT: begin
            if (rsp_take) begin
               k_in = k_ff + CNT_W'(1);
               if (rsp_final) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            count_in = '0;
            ovf_in   = 1'b0;
         end
      endcase
      // Read addresses follow the next positions, so data lines up next cycle
      rd_pos_i = (state_ff == ST_OUT) ? k_in : i_in;
      rd_pos_j = j_in;
   end

   // Channel outputs
   assign req.ready        = state_ff == ST_LOAD;
   assign rsp.valid        = state_ff == ST_OUT;
   assign rsp.sorted_value = head_i;
   assign rsp.end_of_list  = rsp_final;
   assign rsp.overflow     = ovf_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Position registers
   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      width_ff <= width_in;
      mid_ff   <= mid_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      src_ff   <= src_in;
   end

endmodule : list_merge_sorter

`default_nettype wire

@@ hdl/lms_check.sv @@
// Port-level assertions for the list merge sorter, bound to the top level.
// Depends on lms_pkg and list_merge_sorter.
`default_nettype none

module lms_check import lms_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [DATA_W-1:0] rsp_sorted_value,
   input wire logic                     rsp_end_of_list,
   input wire logic                     rsp_overflow
);

   // Out of reset the block collects and shows no result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

   // No input is taken while a sorted list is being delivered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while results pending");

   // Within a list the next beat follows at once and is not smaller
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_end_of_list) |=>
         (rsp_valid && ($past(rsp_sorted_value) <= rsp_sorted_value)))
      else $error("sorted output out of order");

   // Overflow flag is the same on every beat of a list
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_end_of_list) |=>
         (rsp_overflow == $past(rsp_overflow)))
      else $error("overflow flag changed within a list");

   // Stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_end_of_list)))
      else $error("stalled result beat changed");

endmodule : lms_check

bind list_merge_sorter lms_check u_lms_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_sorted_value (rsp.sorted_value),
   .rsp_end_of_list  (rsp.end_of_list),
   .rsp_overflow     (rsp.overflow)
);

`default_nettype wire

@@ tb/list_merge_sorter_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for list_merge_sorter: random and directed lists in,
// sorted beats checked against a local stable merge-sort predictor.
// Depends on lms_pkg, lms_if and the list_merge_sorter RTL.

module list_merge_sorter_tb;
   import lms_pkg::*;

   localparam int MAX_ITEMS   = 64;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_BEATS = 60;
   localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } list_beat_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     end_of_list;
      logic                     overflow;
   } sorted_beat_type;

   logic clock = 1'b0;
   logic reset;

   lms_req_if req_ch ();
   lms_rsp_if rsp_ch ();

   list_merge_sorter #(.MAX_ITEMS(MAX_ITEMS)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Clock: 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   list_beat_type   pending_values[$];
   sorted_beat_type expected_beats[$];
   int              send_idle_pct = 0;
   int              stall_pct     = 0;
   int              error_count   = 0;
   int              cycle_count   = 0;

   // Predictor state: the list collected so far
   logic signed [DATA_W-1:0] list_store[MAX_ITEMS];
   int                       list_len      = 0;
   logic                     list_overflow = 1'b0;

   // Store one accepted value; on the last one, sort stably and queue the beats
   function automatic void take_value(input logic signed [DATA_W-1:0] v,
                                      input logic lst);
      logic signed [DATA_W-1:0] scratch[MAX_ITEMS];
      sorted_beat_type beat;
      int w, lo, mid, hi, i, j, k;
      if (list_len < MAX_ITEMS) begin
         list_store[list_len] = v;
         list_len++;
      end else begin
         list_overflow = 1'b1;
      end
      if (!lst) return;
      // bottom-up merge passes, left run wins ties
      for (w = 1; w < list_len; w = w * 2) begin
         for (lo = 0; lo < list_len; lo = lo + 2 * w) begin
            mid = (lo + w < list_len) ? lo + w : list_len;
            hi  = (lo + 2 * w < list_len) ? lo + 2 * w : list_len;
            i = lo;
            j = mid;
            for (k = lo; k < hi; k++) begin
               if (j >= hi || (i < mid && list_store[i] <= list_store[j])) begin
                  scratch[k] = list_store[i];
                  i++;
               end else begin
                  scratch[k] = list_store[j];
                  j++;
               end
            end
         end
         for (k = 0; k < list_len; k++) list_store[k] = scratch[k];
      end
      for (k = 0; k < list_len; k++) begin
         beat.sorted_value = list_store[k];
         beat.end_of_list  = (k == list_len - 1);
         beat.overflow     = list_overflow;
         expected_beats.push_back(beat);
      end
      list_len      = 0;
      list_overflow = 1'b0;
   endfunction

   // Driver: presents queued values, idles at random per phase
   always @(posedge clock) begin : drive_values
      list_beat_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.value <= '0;
         req_ch.last  <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) take_value(req_ch.value, req_ch.last);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_values.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.value <= nxt.value;
               req_ch.last  <= nxt.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each sorted beat against the oldest expectation
   always @(posedge clock) begin : check_beats
      sorted_beat_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat: value %0d end %b ovf %b", $time,
                        rsp_ch.sorted_value, rsp_ch.end_of_list, rsp_ch.overflow);
               error_count++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_ch.sorted_value !== want.sorted_value) begin
                  $display("%0t: sorted_value expected %0d actual %0d", $time,
                           want.sorted_value, rsp_ch.sorted_value);
                  error_count++;
               end
               if (rsp_ch.end_of_list !== want.end_of_list) begin
                  $display("%0t: end_of_list expected %b actual %b", $time,
                           want.end_of_list, rsp_ch.end_of_list);
                  error_count++;
               end
               if (rsp_ch.overflow !== want.overflow) begin
                  $display("%0t: overflow expected %b actual %b", $time,
                           want.overflow, rsp_ch.overflow);
                  error_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("list_merge_sorter_tb: errors");
         $finish;
      end
   end

   task automatic push_value(input logic signed [DATA_W-1:0] v, input logic lst);
      list_beat_type b;
      b.value = v;
      b.last  = lst;
      pending_values.push_back(b);
   endtask

   // Stimulus: directed lists, then four random phases with different idling
   initial begin : stimulus
      int ph, phase_items, len, n;
      logic signed [DATA_W-1:0] v;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-value lists at both extremes
      push_value(VAL_MIN, 1'b1);
      push_value(VAL_MAX, 1'b1);
      // mixed extremes with duplicates
      push_value(5, 1'b0);
      push_value(-1, 1'b0);
      push_value(0, 1'b0);
      push_value(VAL_MAX, 1'b0);
      push_value(VAL_MIN, 1'b0);
      push_value(-1, 1'b0);
      push_value(5, 1'b1);
      // strictly descending
      for (n = 3; n >= -3; n--) push_value(n, n == -3);
      // alternating bit patterns
      push_value(32'h5555_5555, 1'b0);
      push_value(32'hAAAA_AAAA, 1'b1);
      // all equal
      push_value(7, 1'b0);
      push_value(7, 1'b0);
      push_value(7, 1'b1);

      for (ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 57; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 57; end
            default: begin send_idle_pct = 32; stall_pct = 32; end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_BEATS) begin
            // one full list in phase 1, one overflowing list in phase 3
            if (phase_items == 0 && ph == 1)
               len = MAX_ITEMS;
            else if (phase_items == 0 && ph == 3)
               len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            else
               len = $urandom_range(1, 12);
            for (n = 0; n < len; n++) begin
               case ($urandom_range(0, 5))
                  0: v = $urandom_range(0, 15) - 8;
                  1: v = VAL_MIN + $urandom_range(0, 3);
                  2: v = VAL_MAX - $urandom_range(0, 3);
                  default: v = $urandom();
               endcase
               push_value(v, n == len - 1);
            end
            phase_items += len;
         end
         // let the phase drain before changing the idling mix
         do @(negedge clock);
         while (pending_values.size() != 0 || req_ch.valid || expected_beats.size() != 0);
      end

      // catch any stray beats
      repeat (600) @(negedge clock);
      if (error_count == 0)
         $display("list_merge_sorter_tb: clean");
      else
         $display("list_merge_sorter_tb: errors");
      $finish;
   end

endmodule : list_merge_sorter_tb
